// ===== hdl/bilinear_image_resizer_unit_assert.svh =====
// Assertion macros for the bilinear image resizer unit.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef BILINEAR_IMAGE_RESIZER_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BIR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bir_pkg.sv =====
// Package for the bilinear image resizer: sizes, widths, codes and pipeline types.
// Used by the top level; depends on nothing.
`default_nettype none

package bir_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 3;
    localparam int PIXEL_BITS   = 8;

    localparam int TGT_LIMIT     = 4096;
    localparam int COORD_BITS    = 12;
    localparam int CH_BITS       = 2;
    localparam int RESULT_BITS   = 8;
    localparam int RESULT_MAX    = (1 << RESULT_BITS) - 1;

    localparam int SW_REG_BITS    = 9;
    localparam int SH_REG_BITS    = 9;
    localparam int TW_REG_BITS    = 13;
    localparam int TH_REG_BITS    = 13;
    localparam int NC_REG_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    localparam int SW_RESET = 256;
    localparam int SH_RESET = 256;
    localparam int TW_RESET = 256;
    localparam int TH_RESET = 256;
    localparam int NC_RESET = 1;

    localparam int XB   = $clog2(MAX_WIDTH);
    localparam int YB   = $clog2(MAX_HEIGHT);
    localparam int SWB  = $clog2(MAX_WIDTH + 1);
    localparam int SHB  = $clog2(MAX_HEIGHT + 1);
    localparam int SZB  = (SWB > SHB) ? SWB : SHB;
    localparam int NCB  = $clog2(MAX_CHANNELS + 1);
    localparam int TB   = $clog2(TGT_LIMIT + 1);
    localparam int DB   = TB + 1;
    localparam int ODDB = COORD_BITS + 1;
    localparam int NB   = ODDB + SZB + 1;
    localparam int QB   = (XB > YB) ? XB : YB;
    localparam int TTB  = 2 * TB;
    localparam int HB   = DB + PIXEL_BITS;
    localparam int NUMB = 2 * DB + PIXEL_BITS;

    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEPS   = (QB + DIV_STAGES - 1) / DIV_STAGES;
    localparam int QBE         = DIV_STAGES * DIV_STEPS;
    localparam int FDIV_STAGES = 4;
    localparam int FDIV_STEPS  = (PIXEL_BITS + FDIV_STAGES - 1) / FDIV_STAGES;
    localparam int QFE         = FDIV_STAGES * FDIV_STEPS;

    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AB          = $clog2(FRAME_DEPTH);
    localparam int NUM_TAPS    = 4;

    localparam int ST_C    = DIV_STAGES + 1;
    localparam int ST_D    = ST_C + 1;
    localparam int ST_E    = ST_D + 1;
    localparam int ST_LAST = ST_E + FDIV_STAGES;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_CHANNEL_COUNT = 3'd4
    } t_cfg_index;

    typedef enum logic {
        ACT_WRITE   = 1'b0,
        ACT_COMPUTE = 1'b1
    } t_action;

    typedef struct packed {
        logic                  valid;
        t_action               act;
        logic                  err;
        logic [CH_BITS-1:0]    ch;
        logic [XB-1:0]         col;
        logic [YB-1:0]         row;
        logic [PIXEL_BITS-1:0] pix;
        logic [SWB-1:0]        sw;
        logic [SHB-1:0]        sh;
        logic [TTB-1:0]        tt;
    } t_ctl;

    typedef struct packed {
        logic [NB-1:0]  rem;
        logic [QBE-1:0] q;
        logic [DB-1:0]  den;
        logic           neg;
    } t_axis;

    typedef struct packed {
        logic [NUMB-1:0] rem;
        logic [QFE-1:0]  q;
    } t_norm;

endpackage

`default_nettype wire

// ===== hdl/bilinear_image_resizer_unit.sv =====
// Top level of the bilinear image resizer: config registers, pipeline and frame stores.
// Depends on bir_pkg, bir_ram and bilinear_image_resizer_unit_assert.svh.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-------------------------------------------------
//   input    | i_valid / o_stall  | i_action i_column i_row i_channel i_pixel_value
//   output   | o_valid / i_stall  | o_result_value o_range_error
//   config   | i_cfg_we           | i_cfg_index i_cfg_data
//
// One transaction enters per cycle while o_stall is low.
// The four neighbor reads go to four copies of the frame store, so no port is shared.
// Reset clears the valid bits and loads the config registers with their reset values; the frame store is not cleared.
// A stalled result freezes the whole pipeline, and o_stall rises in the same cycle.
`default_nettype none

`include "bilinear_image_resizer_unit_assert.svh"

module bilinear_image_resizer_unit
    import bir_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic [COORD_BITS-1:0]     i_column,
    input  logic [COORD_BITS-1:0]     i_row,
    input  logic [CH_BITS-1:0]        i_channel,
    input  logic [PIXEL_BITS-1:0]     i_pixel_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [RESULT_BITS-1:0]    o_result_value,
    output logic                      o_range_error,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    function automatic t_axis axis_div(input t_axis a, input int hi);
        t_axis                 r;
        logic [NB+QBE-1:0]     dsh;
        logic                  ge;
        r = a;
        for (int s = 0; s < DIV_STEPS; s++) begin
            dsh = (NB + QBE)'(r.den) << (hi - s);
            ge  = (NB + QBE)'(r.rem) >= dsh;
            if (ge) begin
                r.rem = r.rem - NB'(dsh);
            end
            r.q = QBE'({r.q, ge});
        end
        return r;
    endfunction

    function automatic t_norm norm_div(input t_norm a, input logic [NUMB-1:0] den,
                                       input int hi);
        t_norm                 r;
        logic [NUMB+QFE-1:0]   dsh;
        logic                  ge;
        r = a;
        for (int s = 0; s < FDIV_STEPS; s++) begin
            dsh = (NUMB + QFE)'(den) << (hi - s);
            ge  = (NUMB + QFE)'(r.rem) >= dsh;
            if (ge) begin
                r.rem = r.rem - NUMB'(dsh);
            end
            r.q = QFE'({r.q, ge});
        end
        return r;
    endfunction

    function automatic logic [AB-1:0] frame_addr(input logic [XB-1:0] x,
                                                 input logic [YB-1:0] y,
                                                 input logic [CH_BITS-1:0] ch);
        return AB'((AB'(y) * AB'(MAX_WIDTH) + AB'(x)) * AB'(MAX_CHANNELS) + AB'(ch));
    endfunction

    logic [SW_REG_BITS-1:0] r_source_width;
    logic [SH_REG_BITS-1:0] r_source_height;
    logic [TW_REG_BITS-1:0] r_target_width;
    logic [TH_REG_BITS-1:0] r_target_height;
    logic [NC_REG_BITS-1:0] r_channel_count;

    logic [SWB-1:0] w_sw;
    logic [SHB-1:0] w_sh;
    logic [TB-1:0]  w_tw;
    logic [TB-1:0]  w_th;
    logic [NCB-1:0] w_nc;
    logic           w_wr_err;
    logic           w_cp_err;
    logic [NB-1:0]  w_prod_x;
    logic [NB-1:0]  w_prod_y;
    logic           w_en;

    t_ctl  r_ctl  [0:ST_LAST];
    t_ctl  n_ctl0;
    t_axis r_ax_x [0:DIV_STAGES];
    t_axis r_ax_y [0:DIV_STAGES];
    t_axis n_ax_x [0:DIV_STAGES];
    t_axis n_ax_y [0:DIV_STAGES];

    t_ctl                  w_mc;
    logic [XB-1:0]         w_x0;
    logic [XB-1:0]         w_x1;
    logic [YB-1:0]         w_y0;
    logic [YB-1:0]         w_y1;
    logic                  w_is_wr;
    logic                  w_mem_we;
    logic [AB-1:0]         w_wr_addr;
    logic [AB-1:0]         w_addr [0:NUM_TAPS-1];
    logic [PIXEL_BITS-1:0] w_pix  [0:NUM_TAPS-1];

    logic [DB-1:0] r_wx0;
    logic [DB-1:0] r_wx1;
    logic [DB-1:0] r_wy0;
    logic [DB-1:0] r_wy1;
    logic [HB-1:0] r_h0;
    logic [HB-1:0] r_h1;
    logic [DB-1:0] r_wy0_d;
    logic [DB-1:0] r_wy1_d;

    t_norm r_fd [0:FDIV_STAGES];
    t_norm n_fd [0:FDIV_STAGES];
    t_ctl  w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= SW_REG_BITS'(SW_RESET);
            r_source_height <= SH_REG_BITS'(SH_RESET);
            r_target_width  <= TW_REG_BITS'(TW_RESET);
            r_target_height <= TH_REG_BITS'(TH_RESET);
            r_channel_count <= NC_REG_BITS'(NC_RESET);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data[SW_REG_BITS-1:0];
                CFG_SOURCE_HEIGHT: r_source_height <= i_cfg_data[SH_REG_BITS-1:0];
                CFG_TARGET_WIDTH:  r_target_width  <= i_cfg_data[TW_REG_BITS-1:0];
                CFG_TARGET_HEIGHT: r_target_height <= i_cfg_data[TH_REG_BITS-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[NC_REG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_sw = (r_source_width == '0) ? SWB'(1) :
               (int'(r_source_width) > MAX_WIDTH) ? SWB'(MAX_WIDTH) : SWB'(r_source_width);
        w_sh = (r_source_height == '0) ? SHB'(1) :
               (int'(r_source_height) > MAX_HEIGHT) ? SHB'(MAX_HEIGHT) : SHB'(r_source_height);
        w_tw = (r_target_width == '0) ? TB'(1) :
               (int'(r_target_width) > TGT_LIMIT) ? TB'(TGT_LIMIT) : TB'(r_target_width);
        w_th = (r_target_height == '0) ? TB'(1) :
               (int'(r_target_height) > TGT_LIMIT) ? TB'(TGT_LIMIT) : TB'(r_target_height);
        w_nc = (r_channel_count == '0) ? NCB'(1) :
               (int'(r_channel_count) > MAX_CHANNELS) ? NCB'(MAX_CHANNELS) :
               NCB'(r_channel_count);

        w_wr_err = (int'(i_column) >= int'(w_sw)) || (int'(i_row) >= int'(w_sh)) ||
                   (int'(i_channel) >= int'(w_nc));
        w_cp_err = (int'(i_column) >= int'(w_tw)) || (int'(i_row) >= int'(w_th)) ||
                   (int'(i_channel) >= int'(w_nc));

        n_ctl0.valid = i_valid;
        n_ctl0.act   = t_action'(i_action);
        n_ctl0.err   = (t_action'(i_action) == ACT_WRITE) ? w_wr_err : w_cp_err;
        n_ctl0.ch    = i_channel;
        n_ctl0.col   = XB'(i_column);
        n_ctl0.row   = YB'(i_row);
        n_ctl0.pix   = i_pixel_value;
        n_ctl0.sw    = w_sw;
        n_ctl0.sh    = w_sh;
        n_ctl0.tt    = TTB'(w_tw) * TTB'(w_th);

        w_prod_x = NB'({i_column, 1'b1}) * NB'(w_sw);
        w_prod_y = NB'({i_row, 1'b1}) * NB'(w_sh);

        n_ax_x[0].neg = w_prod_x < NB'(w_tw);
        n_ax_x[0].rem = n_ax_x[0].neg ? w_prod_x + NB'(w_tw) : w_prod_x - NB'(w_tw);
        n_ax_x[0].q   = '0;
        n_ax_x[0].den = {w_tw, 1'b0};
        n_ax_y[0].neg = w_prod_y < NB'(w_th);
        n_ax_y[0].rem = n_ax_y[0].neg ? w_prod_y + NB'(w_th) : w_prod_y - NB'(w_th);
        n_ax_y[0].q   = '0;
        n_ax_y[0].den = {w_th, 1'b0};

        for (int g = 1; g <= DIV_STAGES; g++) begin
            n_ax_x[g] = axis_div(r_ax_x[g-1], QBE - 1 - (g - 1) * DIV_STEPS);
            n_ax_y[g] = axis_div(r_ax_y[g-1], QBE - 1 - (g - 1) * DIV_STEPS);
        end
    end

    assign o_valid = w_last.valid && (w_last.act == ACT_COMPUTE || w_last.err);
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= ST_LAST; i++) begin
                r_ctl[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_ctl[0] <= n_ctl0;
            for (int i = 1; i <= ST_LAST; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                r_ax_x[i] <= n_ax_x[i];
                r_ax_y[i] <= n_ax_y[i];
            end
        end
    end

    always_comb begin
        w_mc = r_ctl[DIV_STAGES];
        w_x0 = XB'(r_ax_x[DIV_STAGES].q);
        w_y0 = YB'(r_ax_y[DIV_STAGES].q);
        if (r_ax_x[DIV_STAGES].neg) begin
            w_x1 = '0;
        end else if (int'(r_ax_x[DIV_STAGES].q) + 1 >= int'(w_mc.sw)) begin
            w_x1 = XB'(int'(w_mc.sw) - 1);
        end else begin
            w_x1 = XB'(int'(r_ax_x[DIV_STAGES].q) + 1);
        end
        if (r_ax_y[DIV_STAGES].neg) begin
            w_y1 = '0;
        end else if (int'(r_ax_y[DIV_STAGES].q) + 1 >= int'(w_mc.sh)) begin
            w_y1 = YB'(int'(w_mc.sh) - 1);
        end else begin
            w_y1 = YB'(int'(r_ax_y[DIV_STAGES].q) + 1);
        end
        w_is_wr   = w_mc.act == ACT_WRITE;
        w_mem_we  = w_mc.valid && w_is_wr && !w_mc.err && w_en;
        w_wr_addr = frame_addr(w_mc.col, w_mc.row, w_mc.ch);
        w_addr[0] = w_is_wr ? w_wr_addr : frame_addr(w_x0, w_y0, w_mc.ch);
        w_addr[1] = w_is_wr ? w_wr_addr : frame_addr(w_x1, w_y0, w_mc.ch);
        w_addr[2] = w_is_wr ? w_wr_addr : frame_addr(w_x0, w_y1, w_mc.ch);
        w_addr[3] = w_is_wr ? w_wr_addr : frame_addr(w_x1, w_y1, w_mc.ch);
    end

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_store
        bir_ram #(
            .WIDTH(PIXEL_BITS),
            .DEPTH(FRAME_DEPTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_mem_we),
            .i_re   (w_en),
            .i_addr (w_addr[k]),
            .i_wdata(w_mc.pix),
            .o_rdata(w_pix[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wx0   <= r_ax_x[DIV_STAGES].den - DB'(r_ax_x[DIV_STAGES].rem);
            r_wx1   <= DB'(r_ax_x[DIV_STAGES].rem);
            r_wy0   <= r_ax_y[DIV_STAGES].den - DB'(r_ax_y[DIV_STAGES].rem);
            r_wy1   <= DB'(r_ax_y[DIV_STAGES].rem);
            r_h0    <= HB'(r_wx0) * HB'(w_pix[0]) + HB'(r_wx1) * HB'(w_pix[1]);
            r_h1    <= HB'(r_wx0) * HB'(w_pix[2]) + HB'(r_wx1) * HB'(w_pix[3]);
            r_wy0_d <= r_wy0;
            r_wy1_d <= r_wy1;
            for (int i = 0; i <= FDIV_STAGES; i++) begin
                r_fd[i] <= n_fd[i];
            end
        end
    end

    always_comb begin
        n_fd[0].rem = NUMB'(r_wy0_d) * NUMB'(r_h0) + NUMB'(r_wy1_d) * NUMB'(r_h1) +
                      (NUMB'(r_ctl[ST_D].tt) << 1);
        n_fd[0].q   = '0;
        for (int g = 1; g <= FDIV_STAGES; g++) begin
            n_fd[g] = norm_div(r_fd[g-1], NUMB'(r_ctl[ST_E+g-1].tt) << 2,
                               QFE - 1 - (g - 1) * FDIV_STEPS);
        end
        w_last = r_ctl[ST_LAST];
        o_range_error = w_last.err;
        if (w_last.err) begin
            o_result_value = '0;
        end else if (int'(r_fd[FDIV_STAGES].q) > RESULT_MAX) begin
            o_result_value = RESULT_BITS'(RESULT_MAX);
        end else begin
            o_result_value = RESULT_BITS'(r_fd[FDIV_STAGES].q);
        end
    end

    `BIR_ASSERT_IMP(a_err_result_zero, o_valid && o_range_error, o_result_value == '0, "Range error result carries a nonzero value.")
    `BIR_ASSERT_IMP(a_index_in_frame, w_mc.valid && w_mc.act == ACT_COMPUTE && !w_mc.err, (int'(r_ax_x[DIV_STAGES].q) < int'(w_mc.sw)) && (int'(r_ax_y[DIV_STAGES].q) < int'(w_mc.sh)), "Neighbor index lies outside the source frame.")
    `BIR_ASSERT_IMP(a_frac_below_den, w_mc.valid && w_mc.act == ACT_COMPUTE && !w_mc.err, (r_ax_x[DIV_STAGES].rem < NB'(r_ax_x[DIV_STAGES].den)) && (r_ax_y[DIV_STAGES].rem < NB'(r_ax_y[DIV_STAGES].den)), "Axis fraction is not below its denominator.")
    `BIR_ASSERT_NXT(a_num_bounded, w_en && r_ctl[ST_D].valid && r_ctl[ST_D].act == ACT_COMPUTE && !r_ctl[ST_D].err, r_fd[0].rem < (NUMB'(r_ctl[ST_E].tt) << (2 + PIXEL_BITS)), "Weighted sum exceeds the pixel range.")

endmodule

`default_nettype wire

// ===== hdl/bir_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing; width and depth are parameters.
`default_nettype none

module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
